@@ hdl/double_row_layout_cost_assert.svh @@
// Assertion macros used by the checker of this block.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef DOUBLE_ROW_LAYOUT_COST_ASSERT_SVH
`define DOUBLE_ROW_LAYOUT_COST_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define DRLC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DRLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/drlc_pkg.sv @@
`default_nettype none

package drlc_pkg;

  localparam int MAX_ROOMS   = 16;
  localparam int LENGTH_BITS = 16;
  localparam int WEIGHT_BITS = 16;

  localparam int OP_BITS        = 2;
  localparam int ID_BITS        = 4;
  localparam int IN_LEN_BITS    = 16;
  localparam int IN_WT_BITS     = 16;
  localparam int ROOM_COST_BITS = 41;
  localparam int TOTAL_BITS     = 48;

  localparam int IDX_BITS   = $clog2(MAX_ROOMS);
  localparam int CNT_BITS   = $clog2(MAX_ROOMS + 1);
  localparam int LIST_AW    = IDX_BITS + 1;
  localparam int LIST_DEPTH = 2 ** LIST_AW;
  localparam int WT_AW      = 2 * ID_BITS;
  localparam int WT_DEPTH   = 2 ** WT_AW;
  // A centre is twice the start plus the length, in half units.
  localparam int CEN_BITS   = LENGTH_BITS + 1 + IDX_BITS;
  localparam int PROD_BITS  = CEN_BITS + WEIGHT_BITS;

  typedef enum logic [OP_BITS-1:0] {
    OP_WRITE  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_EVAL   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP_RD,
    ST_PREP_WR,
    ST_LOAD_A,
    ST_LATCH_A,
    ST_PAIRS,
    ST_EMIT_ROOM,
    ST_EMIT_TOTAL
  } state_t;

  typedef struct packed {
    logic [ID_BITS-1:0]     id;
    logic [LENGTH_BITS-1:0] len;
  } list_entry_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [CEN_BITS-1:0] cen;
  } slot_entry_t;

endpackage

`default_nettype wire

@@ hdl/double_row_layout_cost.sv @@
`default_nettype none

// Two-sided corridor layout cost evaluator. A transaction is taken when start is high and
// busy is low. Weight writes, room appends and layout clears complete in the accepting cycle
// and leave busy low. An evaluate keeps busy high until its total has been shown; its running time
// is set by the single read port of the slot memory and the one shared multiplier, which visit
// every ordered pair of rooms once. Results appear with out_valid high for exactly one cycle each:
// one per placed room, top side first and then bottom, followed by the total with out_last high.
// The receiver cannot stall, so it must take every result in the cycle in which it is shown.
module double_row_layout_cost import drlc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [OP_BITS-1:0]        in_op,
  input  logic [ID_BITS-1:0]        in_room_id,
  input  logic [ID_BITS-1:0]        in_other_room,
  input  logic [IN_WT_BITS-1:0]     in_weight,
  input  logic                      in_side,
  input  logic [IN_LEN_BITS-1:0]    in_room_length,
  output logic                      out_valid,
  output logic [ID_BITS-1:0]        out_placed_room,
  output logic [ROOM_COST_BITS-1:0] out_room_cost,
  output logic [TOTAL_BITS-1:0]     out_total_cost,
  output logic                      out_last
);

  localparam logic [CNT_BITS-1:0] MAX_CNT = CNT_BITS'(MAX_ROOMS);

  state_t                    state_r, state_nxt;
  logic [CNT_BITS-1:0]       top_cnt_r, top_cnt_nxt;
  logic [CNT_BITS-1:0]       bot_cnt_r, bot_cnt_nxt;
  logic [CNT_BITS-1:0]       p_r, p_nxt;
  logic [CNT_BITS-1:0]       a_r, a_nxt;
  logic [CNT_BITS-1:0]       b_r, b_nxt;
  logic [CEN_BITS-1:0]       start_r, start_nxt;
  logic [ID_BITS-1:0]        ida_r, ida_nxt;
  logic [CEN_BITS-1:0]       cena_r, cena_nxt;
  logic [ROOM_COST_BITS-1:0] acc_r, acc_nxt;
  logic [TOTAL_BITS-1:0]     total_r, total_nxt;

  logic [WEIGHT_BITS-1:0] wt_mem [WT_DEPTH];
  list_entry_t            list_mem [LIST_DEPTH];
  slot_entry_t            slot_mem [MAX_ROOMS];

  logic                   accept;
  op_t                    op;
  logic [CNT_BITS-1:0]    room_cnt;

  logic                   wt_we;
  logic [WT_AW-1:0]       wt_waddr;
  logic [WT_AW-1:0]       wt_raddr;
  logic [WEIGHT_BITS-1:0] wt_rdata_r;

  logic                   list_we;
  logic [LIST_AW-1:0]     list_waddr;
  logic [LIST_AW-1:0]     list_raddr;
  list_entry_t            list_wdata;
  list_entry_t            list_rdata_r;
  logic                   prep_bot;
  logic [CNT_BITS-1:0]    prep_idx;

  logic                   slot_we;
  slot_entry_t            slot_wdata;
  logic [IDX_BITS-1:0]    slot_raddr;
  slot_entry_t            slot_rdata_r;
  logic                   first_of_side;
  logic [CEN_BITS-1:0]    base;

  // Pair pipeline: slot read, weight read and difference, product, accumulate.
  logic                   s1_live_r, s2_live_r, s3_live_r;
  logic                   s2_use_r, s3_use_r;
  logic [CNT_BITS-1:0]    s1_b_r;
  logic [CEN_BITS-1:0]    s1_diff;
  logic                   s1_fwd;
  logic [CEN_BITS-1:0]    s2_diff_r;
  logic                   s2_fwd_r, s3_fwd_r;
  logic [PROD_BITS-1:0]   prod;
  logic [PROD_BITS-1:0]   s3_prod_r;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign op       = op_t'(in_op);
  assign room_cnt = top_cnt_r + bot_cnt_r;

  // Load side of the memories.
  assign wt_we      = accept && (op == OP_WRITE);
  assign wt_waddr   = {in_room_id, in_other_room};
  assign list_we    = accept && (op == OP_APPEND) && (room_cnt != MAX_CNT);
  assign list_waddr = {in_side, in_side ? bot_cnt_r[IDX_BITS-1:0] : top_cnt_r[IDX_BITS-1:0]};
  assign list_wdata = '{id: in_room_id, len: LENGTH_BITS'(in_room_length)};

  // The layout is walked in slot order: top rooms, then bottom rooms.
  assign prep_bot   = (p_r >= top_cnt_r);
  assign prep_idx   = prep_bot ? (p_r - top_cnt_r) : p_r;
  assign list_raddr = {prep_bot, prep_idx[IDX_BITS-1:0]};

  // Each side is packed from position zero, so the running start restarts per side.
  assign first_of_side = (p_r == '0) || (p_r == top_cnt_r);
  assign base          = first_of_side ? '0 : start_r;
  assign slot_we       = (state_r == ST_PREP_WR);
  assign slot_wdata    = '{id: list_rdata_r.id,
                           cen: (base << 1) + CEN_BITS'(list_rdata_r.len)};
  assign slot_raddr    = (state_r == ST_LOAD_A) ? a_r[IDX_BITS-1:0] : b_r[IDX_BITS-1:0];

  // The weight is read in the orientation of the earlier slot to the later one.
  assign s1_fwd   = (a_r < s1_b_r);
  assign s1_diff  = (cena_r >= slot_rdata_r.cen) ? (cena_r - slot_rdata_r.cen)
                                                 : (slot_rdata_r.cen - cena_r);
  assign wt_raddr = s1_fwd ? {ida_r, slot_rdata_r.id} : {slot_rdata_r.id, ida_r};
  assign prod     = PROD_BITS'(wt_rdata_r) * PROD_BITS'(s2_diff_r);

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= WEIGHT_BITS'(in_weight);
    end
    wt_rdata_r <= wt_mem[wt_raddr];
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    list_rdata_r <= list_mem[list_raddr];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[p_r[IDX_BITS-1:0]] <= slot_wdata;
    end
    slot_rdata_r <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    s1_b_r    <= b_r;
    s2_diff_r <= s1_diff;
    s2_fwd_r  <= s1_fwd;
    s3_fwd_r  <= s2_fwd_r;
    s3_prod_r <= prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_live_r <= 1'b0;
      s2_live_r <= 1'b0;
      s3_live_r <= 1'b0;
      s2_use_r  <= 1'b0;
      s3_use_r  <= 1'b0;
    end else begin
      s1_live_r <= (state_r == ST_PAIRS) && (b_r != room_cnt);
      s2_live_r <= s1_live_r;
      s3_live_r <= s2_live_r;
      // A slot paired with itself contributes nothing and its weight is never used.
      s2_use_r  <= s1_live_r && (s1_b_r != a_r);
      s3_use_r  <= s2_use_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      top_cnt_r <= '0;
      bot_cnt_r <= '0;
      p_r       <= '0;
      a_r       <= '0;
      b_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      top_cnt_r <= top_cnt_nxt;
      bot_cnt_r <= bot_cnt_nxt;
      p_r       <= p_nxt;
      a_r       <= a_nxt;
      b_r       <= b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    ida_r   <= ida_nxt;
    cena_r  <= cena_nxt;
    acc_r   <= acc_nxt;
    total_r <= total_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    top_cnt_nxt = top_cnt_r;
    bot_cnt_nxt = bot_cnt_r;
    p_nxt       = p_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    start_nxt   = start_r;
    ida_nxt     = ida_r;
    cena_nxt    = cena_r;
    acc_nxt     = acc_r;
    total_nxt   = total_r;

    // Every ordered pair adds to the room's own cost; only the forward one adds to the total.
    if (s3_use_r) begin
      acc_nxt = acc_r + ROOM_COST_BITS'(s3_prod_r);
      if (s3_fwd_r) begin
        total_nxt = total_r + TOTAL_BITS'(s3_prod_r);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_WRITE: begin
            end
            OP_APPEND: begin
              if (room_cnt != MAX_CNT) begin
                if (in_side) begin
                  bot_cnt_nxt = bot_cnt_r + 1'b1;
                end else begin
                  top_cnt_nxt = top_cnt_r + 1'b1;
                end
              end
            end
            OP_CLEAR: begin
              top_cnt_nxt = '0;
              bot_cnt_nxt = '0;
            end
            OP_EVAL: begin
              total_nxt = '0;
              p_nxt     = '0;
              a_nxt     = '0;
              state_nxt = (room_cnt == '0) ? ST_EMIT_TOTAL : ST_PREP_RD;
            end
          endcase
        end
      end
      ST_PREP_RD: begin
        state_nxt = ST_PREP_WR;
      end
      ST_PREP_WR: begin
        start_nxt = base + CEN_BITS'(list_rdata_r.len);
        p_nxt     = p_r + 1'b1;
        state_nxt = (CNT_BITS'(p_r + 1'b1) == room_cnt) ? ST_LOAD_A : ST_PREP_RD;
      end
      ST_LOAD_A: begin
        state_nxt = ST_LATCH_A;
      end
      ST_LATCH_A: begin
        ida_nxt   = slot_rdata_r.id;
        cena_nxt  = slot_rdata_r.cen;
        acc_nxt   = '0;
        b_nxt     = '0;
        state_nxt = ST_PAIRS;
      end
      ST_PAIRS: begin
        if (b_r != room_cnt) begin
          b_nxt = b_r + 1'b1;
        end else if (!s1_live_r && !s2_live_r && !s3_live_r) begin
          state_nxt = ST_EMIT_ROOM;
        end
      end
      ST_EMIT_ROOM: begin
        a_nxt     = a_r + 1'b1;
        state_nxt = (CNT_BITS'(a_r + 1'b1) == room_cnt) ? ST_EMIT_TOTAL : ST_LOAD_A;
      end
      ST_EMIT_TOTAL: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid       = (state_r == ST_EMIT_ROOM) || (state_r == ST_EMIT_TOTAL);
  assign out_last        = (state_r == ST_EMIT_TOTAL);
  assign out_placed_room = (state_r == ST_EMIT_ROOM) ? ida_r : '0;
  assign out_room_cost   = (state_r == ST_EMIT_ROOM) ? acc_r : '0;
  assign out_total_cost  = (state_r == ST_EMIT_TOTAL) ? total_r : '0;

endmodule

`default_nettype wire

@@ hdl/drlc_checker.sv @@
`default_nettype none

`include "double_row_layout_cost_assert.svh"

module drlc_checker import drlc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [OP_BITS-1:0]    in_op,
  input logic                  out_valid,
  input logic                  out_last,
  input logic [TOTAL_BITS-1:0] out_total_cost
);

  // An evaluate always produces at least the total, so the block must go busy.
  `DRLC_ASSERT_NEXT(a_eval_goes_busy, start && !busy && in_op == OP_EVAL, busy, "evaluate did not raise busy")

  // Writes, appends and clears finish in the accepting cycle.
  `DRLC_ASSERT_NEXT(a_quiet_stays_idle, start && !busy && in_op != OP_EVAL, !busy, "quiet transaction raised busy")

  // The total closes an evaluation, after which the block is ready again.
  `DRLC_ASSERT_NEXT(a_idle_after_total, out_valid && out_last, !busy, "busy held after the total")

  // Room results carry no total.
  `DRLC_ASSERT_SAME(a_room_total_zero, out_valid && !out_last, out_total_cost == '0, "room result carries a total")

endmodule

bind double_row_layout_cost drlc_checker u_drlc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_op          (in_op),
  .out_valid      (out_valid),
  .out_last       (out_last),
  .out_total_cost (out_total_cost)
);

`default_nettype wire

@@ tb/tb_double_row_layout_cost.sv @@
`timescale 1ns / 100ps

module tb_double_row_layout_cost;
  import drlc_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 10;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    op_t                    op;
    logic [ID_BITS-1:0]     room;
    logic [ID_BITS-1:0]     other;
    logic [IN_WT_BITS-1:0]  weight;
    logic                   side;
    logic [IN_LEN_BITS-1:0] length;
  } layout_cmd_t;

  typedef struct {
    logic [ID_BITS-1:0]        room;
    logic [ROOM_COST_BITS-1:0] cost;
    logic [TOTAL_BITS-1:0]     total;
    logic                      is_last;
  } cost_item_t;

  class layout_cost_tracker;
    logic [WEIGHT_BITS-1:0] weights [WT_DEPTH];
    bit                     written [WT_DEPTH];
    list_entry_t            top_rooms [MAX_ROOMS];
    list_entry_t            bottom_rooms [MAX_ROOMS];
    int                     top_count = 0;
    int                     bottom_count = 0;
    cost_item_t             pending_costs [$];
    int                     faults = 0;

    // Returns 0 when the command is dropped, which only happens to an append on a full layout.
    function bit take_command(layout_cmd_t c);
      slot_entry_t               slots [2*MAX_ROOMS];
      logic [ROOM_COST_BITS-1:0] room_costs [2*MAX_ROOMS];
      logic [TOTAL_BITS-1:0]     total;
      logic [CEN_BITS-1:0]       run_start;
      logic [CEN_BITS-1:0]       gap;
      logic [PROD_BITS-1:0]      prod;
      cost_item_t                item;
      int                        n;
      case (c.op)
        OP_WRITE: begin
          weights[{c.room, c.other}] = c.weight[WEIGHT_BITS-1:0];
          written[{c.room, c.other}] = 1'b1;
        end
        OP_APPEND: begin
          if (top_count + bottom_count >= MAX_ROOMS) return 1'b0;
          if (c.side == 1'b0) begin
            top_rooms[top_count].id  = c.room;
            top_rooms[top_count].len = c.length[LENGTH_BITS-1:0];
            top_count = top_count + 1;
          end else begin
            bottom_rooms[bottom_count].id  = c.room;
            bottom_rooms[bottom_count].len = c.length[LENGTH_BITS-1:0];
            bottom_count = bottom_count + 1;
          end
        end
        OP_CLEAR: begin
          top_count    = 0;
          bottom_count = 0;
        end
        OP_EVAL: begin
          // Centres in half units: twice the start plus the length, each side packed from zero.
          n = 0;
          run_start = '0;
          for (int i = 0; i < top_count; i++) begin
            slots[n].id  = top_rooms[i].id;
            slots[n].cen = {run_start[CEN_BITS-2:0], 1'b0} + CEN_BITS'(top_rooms[i].len);
            run_start = run_start + CEN_BITS'(top_rooms[i].len);
            n = n + 1;
          end
          run_start = '0;
          for (int i = 0; i < bottom_count; i++) begin
            slots[n].id  = bottom_rooms[i].id;
            slots[n].cen = {run_start[CEN_BITS-2:0], 1'b0} + CEN_BITS'(bottom_rooms[i].len);
            run_start = run_start + CEN_BITS'(bottom_rooms[i].len);
            n = n + 1;
          end
          for (int a = 0; a < n; a++) room_costs[a] = '0;
          total = '0;
          // Top rooms come before bottom rooms, so the earlier slot is always the weight row.
          for (int a = 0; a < n; a++) begin
            for (int b = a + 1; b < n; b++) begin
              gap = (slots[a].cen > slots[b].cen) ? slots[a].cen - slots[b].cen
                                                  : slots[b].cen - slots[a].cen;
              prod = PROD_BITS'(gap) * PROD_BITS'(weights[{slots[a].id, slots[b].id}]);
              room_costs[a] = room_costs[a] + ROOM_COST_BITS'(prod);
              room_costs[b] = room_costs[b] + ROOM_COST_BITS'(prod);
              total = total + TOTAL_BITS'(prod);
            end
          end
          for (int a = 0; a < n; a++) begin
            item.room    = slots[a].id;
            item.cost    = room_costs[a];
            item.total   = '0;
            item.is_last = 1'b0;
            pending_costs = {pending_costs, item};
          end
          item.room    = '0;
          item.cost    = '0;
          item.total   = total;
          item.is_last = 1'b1;
          pending_costs = {pending_costs, item};
        end
        default: ;
      endcase
      return 1'b1;
    endfunction

    function void match_cost(logic [ID_BITS-1:0] room, logic [ROOM_COST_BITS-1:0] cost,
                             logic [TOTAL_BITS-1:0] total, logic is_last);
      cost_item_t want;
      if (pending_costs.size() == 0) begin
        if (faults < REPORT_LIMIT)
          $display("unexpected result: room %0d cost %0d total %0d last %0b",
                   room, cost, total, is_last);
        faults = faults + 1;
        return;
      end
      want = pending_costs.pop_front();
      if (room !== want.room || cost !== want.cost || total !== want.total ||
          is_last !== want.is_last) begin
        if (faults < REPORT_LIMIT)
          $display("result mismatch: expected room %0d cost %0d total %0d last %0b,",
                   want.room, want.cost, want.total, want.is_last,
                   " got room %0d cost %0d total %0d last %0b",
                   room, cost, total, is_last);
        faults = faults + 1;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [OP_BITS-1:0]        in_op = '0;
  logic [ID_BITS-1:0]        in_room_id = '0;
  logic [ID_BITS-1:0]        in_other_room = '0;
  logic [IN_WT_BITS-1:0]     in_weight = '0;
  logic                      in_side = 1'b0;
  logic [IN_LEN_BITS-1:0]    in_room_length = '0;
  logic                      out_valid;
  logic [ID_BITS-1:0]        out_placed_room;
  logic [ROOM_COST_BITS-1:0] out_room_cost;
  logic [TOTAL_BITS-1:0]     out_total_cost;
  logic                      out_last;

  layout_cost_tracker layout_costs = new();
  int idle_pct = 0;
  int items_done = 0;
  int cycles = 0;

  double_row_layout_cost i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_room_id      (in_room_id),
    .in_other_room   (in_other_room),
    .in_weight       (in_weight),
    .in_side         (in_side),
    .in_room_length  (in_room_length),
    .out_valid       (out_valid),
    .out_placed_room (out_placed_room),
    .out_room_cost   (out_room_cost),
    .out_total_cost  (out_total_cost),
    .out_last        (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      layout_costs.match_cost(out_placed_room, out_room_cost, out_total_cost, out_last);
  end

  function automatic layout_cmd_t random_cmd(op_t op);
    layout_cmd_t c;
    c.op    = op;
    c.room  = ID_BITS'($urandom_range(0, 15));
    c.other = ID_BITS'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       c.weight = '0;
      1:       c.weight = '1;
      default: c.weight = IN_WT_BITS'($urandom_range(0, 65535));
    endcase
    c.side = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0:       c.length = '0;
      1:       c.length = '1;
      default: c.length = IN_LEN_BITS'($urandom_range(0, 65535));
    endcase
    return c;
  endfunction

  task automatic send(layout_cmd_t c);
    start          <= 1'b1;
    in_op          <= c.op;
    in_room_id     <= c.room;
    in_other_room  <= c.other;
    in_weight      <= c.weight;
    in_side        <= c.side;
    in_room_length <= c.length;
    do @(posedge clk); while (busy);
    if (layout_costs.take_command(c)) items_done = items_done + 1;
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Every weight that the coming evaluate uses is written first, so no unwritten entry is used.
  task automatic send_evaluate();
    logic [ID_BITS-1:0] ids [2*MAX_ROOMS];
    layout_cmd_t        c;
    int                 n;
    n = 0;
    for (int i = 0; i < layout_costs.top_count; i++) begin
      ids[n] = layout_costs.top_rooms[i].id;
      n = n + 1;
    end
    for (int i = 0; i < layout_costs.bottom_count; i++) begin
      ids[n] = layout_costs.bottom_rooms[i].id;
      n = n + 1;
    end
    for (int a = 0; a < n; a++) begin
      for (int b = a + 1; b < n; b++) begin
        if (!layout_costs.written[{ids[a], ids[b]}]) begin
          c = random_cmd(OP_WRITE);
          c.room  = ids[a];
          c.other = ids[b];
          send(c);
        end
      end
    end
    send(random_cmd(OP_EVAL));
  endtask

  task automatic run_layout(int rooms);
    op_t stray;
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        stray = op_t'($urandom_range(0, 3));
        if (stray == OP_EVAL) send_evaluate();
        else send(random_cmd(stray));
      end
    end
    // Now and then the clear is skipped, so layouts pile up and run into the room limit.
    if ($urandom_range(0, 5) != 0) send(random_cmd(OP_CLEAR));
    for (int r = 0; r < rooms; r++) begin
      send(random_cmd(OP_APPEND));
      if ($urandom_range(0, 9) == 0) send(random_cmd(OP_WRITE));
    end
    send_evaluate();
  endtask

  initial begin
    layout_cmd_t c;
    int          phase_idle [4];
    int          target;
    phase_idle = '{0, 80, 8, 0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // An evaluate straight after reset sees an empty layout.
    send_evaluate();

    c = random_cmd(OP_WRITE);
    c.room = 4'd15; c.other = 4'd0; c.weight = '1;
    send(c);
    c = random_cmd(OP_WRITE);
    c.room = 4'd15; c.other = 4'd15; c.weight = '1;
    send(c);
    c = random_cmd(OP_WRITE);
    c.room = 4'd0; c.other = 4'd15; c.weight = '0;
    send(c);

    // Longest rooms on both sides, an empty room on top, and room 15 placed three times.
    c = random_cmd(OP_APPEND);
    c.room = 4'd15; c.side = 1'b0; c.length = '1;
    send(c);
    c = random_cmd(OP_APPEND);
    c.room = 4'd0; c.side = 1'b0; c.length = '0;
    send(c);
    c = random_cmd(OP_APPEND);
    c.room = 4'd15; c.side = 1'b1; c.length = '1;
    send(c);
    c = random_cmd(OP_APPEND);
    c.room = 4'd15; c.side = 1'b1; c.length = 16'd1;
    send(c);
    send_evaluate();
    send(random_cmd(OP_CLEAR));
    send_evaluate();

    // One layout past the room limit, so the final append is dropped.
    run_layout(MAX_ROOMS + 1);

    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      target = items_done + PHASE_ITEMS;
      while (items_done < target) begin
        if ($urandom_range(0, 9) == 0) run_layout($urandom_range(9, MAX_ROOMS + 2));
        else run_layout($urandom_range(0, 6));
      end
    end

    start <= 1'b0;
    while (layout_costs.pending_costs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (layout_costs.faults == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/drlc_pkg.sv
hdl/double_row_layout_cost.sv
hdl/drlc_checker.sv
tb/tb_double_row_layout_cost.sv
